// ----- sv/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- sv/uia_pkg.sv -----
// ----------------------------------------------------------------------------
// uia_pkg
// Types, codes and helpers shared by the id allocator modules.
// ----------------------------------------------------------------------------
package uia_pkg;

	localparam int ID_W    = 8;
	localparam int LIMIT_W = 9;
	localparam int ST_W    = 3;
	localparam int WORD_W  = 16;
	localparam int BPOS_W  = 4;
	localparam int ADDR_W  = 2;
	localparam int DATA_W  = 32;

	localparam logic CMD_ASSIGN  = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	localparam logic [ST_W-1:0] ST_OK        = 3'd0;
	localparam logic [ST_W-1:0] ST_HOLDS     = 3'd1;
	localparam logic [ST_W-1:0] ST_EXHAUSTED = 3'd2;
	localparam logic [ST_W-1:0] ST_EMPTY     = 3'd3;
	localparam logic [ST_W-1:0] ST_NEVER     = 3'd4;
	localparam logic [ST_W-1:0] ST_TWICE     = 3'd5;

	localparam logic [ADDR_W-1:0] ADDR_ID_LIMIT = 2'd0;
	localparam logic [LIMIT_W-1:0] ID_LIMIT_RST = 9'd256;

	typedef struct packed {
		logic capture;
		logic eval;
		logic pick;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_find;
		logic out_free;
	} dp_stat_t;

	// Position of the lowest set bit of a bitmap word.
	function automatic logic [BPOS_W-1:0] lowest16(input logic [WORD_W-1:0] w);
		logic [BPOS_W-1:0] pos;
		pos = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (w[i]) begin
				pos = BPOS_W'(i);
			end
		end
		return pos;
	endfunction

endpackage

// ----- sv/unique_id_allocator.sv -----
// ----------------------------------------------------------------------------
// unique_id_allocator
// Issues unique ids, reusing the lowest released id before fresh ones.
// ----------------------------------------------------------------------------
// One request is in work at a time. A request goes through capture, then
// evaluation, then output; one that reuses a released id adds a step:
// the second step of the bitmap search (lowest nonempty word from the
// summary vector, then the lowest set bit inside that word). A finished word
// waits in the output register while the next request is taken; if that word
// is still stalled when the next result is ready, the request holds in its
// last step, and the input stays stalled, until out_stall drops. The released
// bitmap sits in flip-flops cleared by reset, so no clearing pass is needed.
// id_limit (address 0) is an exclusive bound on fresh ids, capped by the id
// space; it must be written only while the block is idle.
module unique_id_allocator
	import uia_pkg::*;
#(
	parameter int ID_SPACE = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              command,
	input  logic [ID_W-1:0]   current_id,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              ok,
	output logic [ID_W-1:0]   new_id,
	output logic [ST_W-1:0]   status,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	ctrl_cmd_t          cmd;
	dp_stat_t           stat;
	logic [LIMIT_W-1:0] id_limit_q;

	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_ID_LIMIT) ? DATA_W'(id_limit_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_limit_q <= ID_LIMIT_RST;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_ID_LIMIT) begin
			id_limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	uia_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	uia_dpath #(
		.ID_SPACE (ID_SPACE)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.id_limit   (id_limit_q),
		.command    (command),
		.current_id (current_id),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.ok         (ok),
		.new_id     (new_id),
		.status     (status)
	);

endmodule

// ----- sv/uia_ctrl.sv -----
// ----------------------------------------------------------------------------
// uia_ctrl
// Sequencer: takes one request, evaluates it, optionally searches the
// bitmap, then hands the result to the output register.
// ----------------------------------------------------------------------------
module uia_ctrl
	import uia_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EVAL = 2'd1;
	localparam logic [1:0] S_PICK = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = stat.need_find ? S_PICK : S_DONE;
			end
			S_PICK: begin
				cmd.pick = 1'b1;
				state_d  = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- sv/uia_dpath.sv -----
// ----------------------------------------------------------------------------
// uia_dpath
// Released-id bitmap with word summary, fresh-id counter, request decode
// and the output word register.
// ----------------------------------------------------------------------------
module uia_dpath
	import uia_pkg::*;
#(
	parameter int ID_SPACE = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ctrl_cmd_t          cmd,
	output dp_stat_t           stat,
	input  logic [LIMIT_W-1:0] id_limit,
	input  logic               command,
	input  logic [ID_W-1:0]    current_id,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               ok,
	output logic [ID_W-1:0]    new_id,
	output logic [ST_W-1:0]    status
);

	// Ids cannot exceed 8 bits, so the map never holds more than 256 entries.
	localparam int MAP_DEPTH  = (ID_SPACE < 256) ? ID_SPACE : 256;
	localparam int WORDS_NEED = (MAP_DEPTH + WORD_W - 1) / WORD_W;
	localparam int WIDX_W     = (WORDS_NEED > 2) ? $clog2(WORDS_NEED) : 1;
	localparam int NUM_WORDS  = 1 << WIDX_W;
	localparam logic [LIMIT_W-1:0] MAP_LIMIT = LIMIT_W'(MAP_DEPTH);

	logic [WORD_W-1:0]    map_q [NUM_WORDS];
	logic [NUM_WORDS-1:0] summary;
	logic [WIDX_W-1:0]    low_w;
	logic [WIDX_W-1:0]    widx_q;
	logic [LIMIT_W-1:0]   next_fresh_q;

	logic              cmd_q;
	logic [ID_W-1:0]   cur_q;
	logic              pend_ok_q;
	logic [ID_W-1:0]   pend_id_q;
	logic [ST_W-1:0]   pend_st_q;
	logic              out_valid_q;
	logic              ok_q;
	logic [ID_W-1:0]   new_id_q;
	logic [ST_W-1:0]   status_q;

	logic [WIDX_W-1:0] cur_w;
	logic [BPOS_W-1:0] cur_b;
	logic              cur_zero;
	logic              cur_bit;
	logic              any_rel;
	logic [LIMIT_W-1:0] eff_limit;
	logic [LIMIT_W-1:0] cur_ext;
	logic [BPOS_W-1:0] pick_pos;

	logic              res_ok;
	logic [ID_W-1:0]   res_id;
	logic [ST_W-1:0]   res_st;
	logic              set_bit;
	logic              bump;

	always_comb begin
		for (int w = 0; w < NUM_WORDS; w++) begin
			summary[w] = |map_q[w];
		end
	end

	always_comb begin
		low_w = '0;
		for (int w = NUM_WORDS - 1; w >= 0; w--) begin
			if (summary[w]) begin
				low_w = WIDX_W'(w);
			end
		end
	end

	assign any_rel   = |summary;
	assign cur_w     = cur_q[WIDX_W+BPOS_W-1:BPOS_W];
	assign cur_b     = cur_q[BPOS_W-1:0];
	assign cur_zero  = (cur_q == '0);
	assign cur_bit   = map_q[cur_w][cur_b];
	assign cur_ext   = LIMIT_W'(cur_q);
	assign eff_limit = (id_limit > MAP_LIMIT) ? MAP_LIMIT : id_limit;
	assign pick_pos  = lowest16(map_q[widx_q]);

	assign stat.need_find = (cmd_q == CMD_ASSIGN) && cur_zero && any_rel;
	assign stat.out_free  = !out_valid_q || !out_stall;

	// Every request that needs no bitmap search is settled here.
	always_comb begin
		res_ok  = 1'b0;
		res_id  = cur_q;
		res_st  = ST_OK;
		set_bit = 1'b0;
		bump    = 1'b0;
		if (cmd_q == CMD_ASSIGN) begin
			if (!cur_zero) begin
				res_st = ST_HOLDS;
			end else if (next_fresh_q >= eff_limit) begin
				res_st = ST_EXHAUSTED;
				res_id = '0;
			end else begin
				res_ok = 1'b1;
				res_id = next_fresh_q[ID_W-1:0];
				bump   = 1'b1;
			end
		end else begin
			if (cur_zero) begin
				res_st = ST_EMPTY;
			end else if (cur_ext >= next_fresh_q || cur_ext >= MAP_LIMIT) begin
				res_st = ST_NEVER;
			end else if (cur_bit) begin
				res_st = ST_TWICE;
			end else begin
				res_ok  = 1'b1;
				res_id  = '0;
				set_bit = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_fresh_q <= LIMIT_W'(1);
			out_valid_q  <= 1'b0;
			for (int w = 0; w < NUM_WORDS; w++) begin
				map_q[w] <= '0;
			end
		end else begin
			if (cmd.eval && !stat.need_find && bump) begin
				next_fresh_q <= next_fresh_q + 1'b1;
			end
			if (cmd.eval && !stat.need_find && set_bit) begin
				map_q[cur_w][cur_b] <= 1'b1;
			end
			if (cmd.pick) begin
				map_q[widx_q][pick_pos] <= 1'b0;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q <= command;
			cur_q <= current_id;
		end
		if (cmd.eval) begin
			widx_q    <= low_w;
			pend_ok_q <= res_ok;
			pend_id_q <= res_id;
			pend_st_q <= res_st;
		end
		if (cmd.pick) begin
			pend_ok_q <= 1'b1;
			pend_id_q <= ID_W'({widx_q, pick_pos});
			pend_st_q <= ST_OK;
		end
		if (cmd.load_out) begin
			ok_q     <= pend_ok_q;
			new_id_q <= pend_id_q;
			status_q <= pend_st_q;
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign new_id    = new_id_q;
	assign status    = status_q;

endmodule

// ----- sv/uia_checker.sv -----
// ----------------------------------------------------------------------------
// uia_port_checker
// Port-level checks for the id allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uia_port_checker
	import uia_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic              ok,
	input logic [ID_W-1:0]   new_id,
	input logic [ST_W-1:0]   status
);

	// A stalled result word holds.
	`ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(new_id) && $stable(status))

	// Success and the ok status code always travel together.
	`ASSERT_IMP(a_ok_status, out_valid, ok == (status == ST_OK))

	// A failed assign with no id held, or an empty release, reports id 0.
	`ASSERT_IMP(a_zero_id, out_valid && (status == ST_EXHAUSTED || status == ST_EMPTY), new_id == '0)

	// Only one request is in work: the input side closes right after a take.
	`ASSERT_NXT(a_busy, in_valid && !in_stall, in_stall)

endmodule

bind unique_id_allocator uia_port_checker u_uia_checker (.*);
